FILE: hdl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// shared types and constants for the positional list engine
// ----------------------------------------------------------------------------
package plist_pkg;

  // default number of list entries
  localparam int unsigned CAPACITY_DEF = 64;

  // fixed field widths
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned ITEM_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_POS   = 3'd1,
    REQ_INS_BACK  = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_POS   = 3'd4,
    REQ_REM_BACK  = 3'd5,
    REQ_READ      = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;    // capture request fields
    logic    init;    // set up cursor and read count for the shift
    logic    step;    // advance the shift loop
    logic    put;     // write new handle at target slot
    logic    finish;  // publish result, update fill count
    status_e code;    // result status for finish
  } plist_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_e req;
    logic empty;
    logic full;
    logic pos_over;    // position beyond fill count
    logic pos_at_end;  // position at or beyond fill count
    logic shift_last;  // no reads left to issue
  } plist_stat_t;

endpackage

FILE: hdl/plist_ram.sv
// ----------------------------------------------------------------------------
// plist_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module plist_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/plist_ctrl.sv
// ----------------------------------------------------------------------------
// plist_ctrl
// request sequencer: checks, shift loop, insert write and result beat
// ----------------------------------------------------------------------------
module plist_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  plist_pkg::plist_stat_t stat_i,
  output plist_pkg::plist_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SHIFT = 6'b000100,
    S_PUT   = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  plist_pkg::status_e  code_q, code_d;
  logic                is_ins;

  always_comb begin
    case (stat_i.req) inside
      plist_pkg::REQ_INS_FRONT, plist_pkg::REQ_INS_POS,
      plist_pkg::REQ_INS_BACK: is_ins = 1'b1;
      default:                 is_ins = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    cmd_o       = '0;
    cmd_o.code  = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        code_d  = plist_pkg::ST_OK;
        state_d = S_DONE;
        case (stat_i.req) inside
          plist_pkg::REQ_INS_FRONT, plist_pkg::REQ_INS_POS,
          plist_pkg::REQ_INS_BACK: begin
            if (stat_i.req == plist_pkg::REQ_INS_POS && stat_i.pos_over) begin
              code_d = plist_pkg::ST_BADPOS;
            end else if (stat_i.full) begin
              code_d = plist_pkg::ST_FULL;
            end else begin
              cmd_o.init = 1'b1;
              state_d    = S_SHIFT;
            end
          end
          plist_pkg::REQ_REM_FRONT, plist_pkg::REQ_REM_BACK: begin
            if (stat_i.empty) begin
              code_d = plist_pkg::ST_EMPTY;
            end else begin
              cmd_o.init = 1'b1;
              state_d    = S_SHIFT;
            end
          end
          plist_pkg::REQ_REM_POS, plist_pkg::REQ_READ: begin
            if (stat_i.empty) begin
              code_d = plist_pkg::ST_EMPTY;
            end else if (stat_i.pos_at_end) begin
              code_d = plist_pkg::ST_BADPOS;
            end else begin
              cmd_o.init = 1'b1;
              state_d    = S_SHIFT;
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        cmd_o.step = 1'b1;
        if (stat_i.shift_last) begin
          state_d = is_ins ? S_PUT : S_DONE;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= plist_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: hdl/plist_datapath.sv
// ----------------------------------------------------------------------------
// plist_datapath
// request registers, fill count, entry memory with shift cursor, result beat
// ----------------------------------------------------------------------------
module plist_datapath #(
  parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [plist_pkg::REQ_W-1:0]      req_type_i,
  input  logic [plist_pkg::POS_W-1:0]      position_i,
  input  logic [plist_pkg::ITEM_W-1:0]     item_value_i,
  input  plist_pkg::plist_cmd_t            cmd_i,
  output plist_pkg::plist_stat_t           stat_o,
  output logic                             done_o,
  output logic [plist_pkg::ITEM_W-1:0]     item_out_o,
  output logic [plist_pkg::STAT_W-1:0]     status_o,
  output logic [plist_pkg::COUNT_W-1:0]    entry_count_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;

  plist_pkg::req_e                req_q;
  logic [plist_pkg::POS_W-1:0]    pos_q;
  logic [plist_pkg::ITEM_W-1:0]   val_q;
  logic [CW-1:0]                  count_q, count_d;
  logic [AW-1:0]                  cur_q, cur_d;
  logic [CW-1:0]                  left_q, left_d;
  logic                           rv_q, rv_d;
  logic [AW-1:0]                  ra_q, ra_d;
  logic [plist_pkg::ITEM_W-1:0]   item_q, item_d;
  logic [plist_pkg::ITEM_W-1:0]   out_item_q, out_item_d;
  logic [plist_pkg::STAT_W-1:0]   out_stat_q, out_stat_d;
  logic                           done_q, done_d;

  logic [CMPW-1:0]                pos_w, count_w, at_w;
  logic [AW-1:0]                  at_a;
  logic                           is_ins, is_rem;

  logic                           we, re;
  logic [AW-1:0]                  waddr, raddr;
  logic [plist_pkg::ITEM_W-1:0]   wdata, rdata;

  assign pos_w   = CMPW'(pos_q);
  assign count_w = CMPW'(count_q);

  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (req_q) inside
      plist_pkg::REQ_INS_FRONT, plist_pkg::REQ_INS_POS,
      plist_pkg::REQ_INS_BACK: is_ins = 1'b1;
      plist_pkg::REQ_REM_FRONT, plist_pkg::REQ_REM_POS,
      plist_pkg::REQ_REM_BACK: is_rem = 1'b1;
      default: ;
    endcase
  end

  // target slot of the request
  always_comb begin
    case (req_q) inside
      plist_pkg::REQ_INS_POS, plist_pkg::REQ_REM_POS,
      plist_pkg::REQ_READ:     at_w = pos_w;
      plist_pkg::REQ_INS_BACK: at_w = count_w;
      plist_pkg::REQ_REM_BACK: at_w = count_w - CMPW'(1);
      default:                 at_w = '0;
    endcase
  end

  assign at_a = at_w[AW-1:0];

  assign stat_o.req        = req_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.pos_over   = (pos_w > count_w);
  assign stat_o.pos_at_end = (pos_w >= count_w);
  assign stat_o.shift_last = (left_q == '0);

  always_comb begin
    count_d    = count_q;
    cur_d      = cur_q;
    left_d     = left_q;
    rv_d       = rv_q;
    ra_d       = ra_q;
    item_d     = item_q;
    out_item_d = out_item_q;
    out_stat_d = out_stat_q;
    done_d     = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = at_a;
    wdata      = val_q;
    raddr      = cur_q;

    if (cmd_i.load) begin
      item_d = '0;
    end

    if (cmd_i.init) begin
      rv_d = 1'b0;
      if (is_ins) begin
        // open a gap: walk down from the last entry
        cur_d  = AW'(count_w - CMPW'(1));
        left_d = CW'(count_w - at_w);
      end else if (is_rem) begin
        // close the gap: walk up from the target
        cur_d  = at_a;
        left_d = CW'(count_w - at_w);
      end else begin
        cur_d  = at_a;
        left_d = CW'(1);
      end
    end

    if (cmd_i.step) begin
      if (left_q != '0) begin
        re     = 1'b1;
        rv_d   = 1'b1;
        ra_d   = cur_q;
        cur_d  = is_ins ? cur_q - AW'(1) : cur_q + AW'(1);
        left_d = left_q - CW'(1);
      end else begin
        rv_d = 1'b0;
      end
      if (rv_q) begin
        if (is_ins) begin
          we    = 1'b1;
          waddr = ra_q + AW'(1);
          wdata = rdata;
        end else if (is_rem && ra_q != at_a) begin
          we    = 1'b1;
          waddr = ra_q - AW'(1);
          wdata = rdata;
        end else begin
          item_d = rdata;
        end
      end
    end

    if (cmd_i.put) begin
      we    = 1'b1;
      waddr = at_a;
      wdata = val_q;
    end

    if (cmd_i.finish) begin
      done_d     = 1'b1;
      out_stat_d = cmd_i.code;
      out_item_d = (cmd_i.code == plist_pkg::ST_OK) ? item_q : '0;
      if (cmd_i.code == plist_pkg::ST_OK) begin
        if (is_ins) begin
          count_d = count_q + CW'(1);
        end else if (is_rem) begin
          count_d = count_q - CW'(1);
        end
      end
    end
  end

  plist_ram #(
    .WIDTH (plist_pkg::ITEM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= plist_pkg::req_e'(req_type_i);
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    cur_q      <= cur_d;
    ra_q       <= ra_d;
    item_q     <= item_d;
    out_item_q <= out_item_d;
    out_stat_q <= out_stat_d;
  end

  assign done_o        = done_q;
  assign item_out_o    = out_item_q;
  assign status_o      = out_stat_q;
  assign entry_count_o = count_w[plist_pkg::COUNT_W-1:0];

endmodule

FILE: hdl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list of 16-bit handles with positional insert, remove, read
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result beat
// follows, shown for a single cycle with done_o high, and the receiver
// cannot stall it, so it must be captured in that cycle. Entries sit in a
// single-port-write memory, so an insert or remove moves the entries behind
// the target one slot per cycle. busy stays high until the done beat, and the
// next request may be given in that same cycle. A request that cannot be
// carried out (empty list, bad position, full list) leaves the list untouched
// and reports why; item_out_o is zero unless status is ok. entry_count_o
// gives the fill after the request.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          start,
  output logic                          busy,
  input  logic [plist_pkg::REQ_W-1:0]   req_type_i,
  input  logic [plist_pkg::POS_W-1:0]   position_i,
  input  logic [plist_pkg::ITEM_W-1:0]  item_value_i,
  // result side, one beat per request
  output logic                          done_o,
  output logic [plist_pkg::ITEM_W-1:0]  item_out_o,
  output logic [plist_pkg::STAT_W-1:0]  status_o,
  output logic [plist_pkg::COUNT_W-1:0] entry_count_o
);

  // command and status between sequencer and datapath
  plist_pkg::plist_cmd_t  cmd;
  plist_pkg::plist_stat_t stat;

  // sequencer: range checks, shift loop, insert write, result beat
  plist_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // datapath: request latch, fill count, entry memory and output registers
  plist_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .item_out_o    (item_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule
